// ===== design/hyp_pkg.sv =====
// Package for the vector magnitude pipeline: shared constants and widths.
// Used by the top level.
package hyp_pkg;
    localparam int FRAC_W    = 30;
    localparam int RATIO_W   = 32;
    localparam int POLY_W    = 34;
    // rational coefficients, Q4.30
    localparam logic [POLY_W-1:0] CP0 = 34'd79806610;
    localparam logic [POLY_W-1:0] CP1 = 34'd2399895553;
    localparam logic [POLY_W-1:0] CP2 = 34'd5670759153;
    localparam logic [POLY_W-1:0] CP3 = 34'd1591954984;
    localparam logic [POLY_W-1:0] CQ0 = 34'd669336246;
    localparam logic [POLY_W-1:0] CQ1 = 34'd4768523365;
    localparam logic [POLY_W-1:0] CQ2 = 34'd4036121244;
    localparam logic [POLY_W-1:0] CQ3 = 34'd268435456;
    // 1/sqrt(2), Q2.30
    localparam logic [RATIO_W-1:0] INV_SQRT2 = 32'd759250125;
endpackage

// ===== design/hyp_stream_if.sv =====
// Valid/ready stream interface carrying a payload of parameterised width.
// Depends on nothing; used by the top level.
interface hyp_stream_if #(parameter int WIDTH = 32);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/hyp_div_stage.sv =====
// One restoring division step per pipeline stage, numerator/denominator carried along.
// Depends on nothing beyond its parameters; used in chains by the top level.
module hyp_div_stage #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 34,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DEN_W:0]    in_rem,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [DEN_W:0]    out_rem,
    output logic [NUM_W-1:0]  out_num,
    output logic [DEN_W-1:0]  out_den,
    output logic [SIDE_W-1:0] out_side
);
    logic [DEN_W+1:0] trial;
    logic [DEN_W:0]   rem_next;
    logic [NUM_W-1:0] num_next;

    // shift in next numerator bit, subtract when it fits; quotient shifts into num
    always_comb
    begin
        trial = {in_rem, in_num[NUM_W-1]};
        if (trial >= {1'b0, 1'b0, in_den})
        begin
            rem_next = (DEN_W+1)'(trial - {2'b0, in_den});
            num_next = {in_num[NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[DEN_W:0];
            num_next = {in_num[NUM_W-2:0], 1'b0};
        end
    end

    // hold on stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_rem  <= rem_next;
            out_num  <= num_next;
            out_den  <= in_den;
            out_side <= in_side;
        end
    end
endmodule

// ===== design/hypotenuse_rational_newton_top.sv =====
// Top level of the vector magnitude pipeline (rational root guess, Newton step).
// Depends on hyp_pkg, hyp_stream_if and hyp_div_stage.
//
//  channel  | modport | payload
//  in_ch    | sink    | {coord_y, coord_x}, DATA_WIDTH bits each, signed Q16.16
//  out_ch   | source  | magnitude, DATA_WIDTH bits, unsigned Q16.16
//
// One item enters per cycle unless out_ch stalls. The pipeline has 200 register
// stages, most of them in three bit-serial dividers (ratio, rational quotient,
// Newton quotient) of 62 stages each, one quotient bit per stage. rst_n clears all
// valid bits at once. A stall on out_ch freezes the whole pipeline in place; a free
// output slot lets it advance.
module hypotenuse_rational_newton_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic  clk,
    input  logic  rst_n,
    hyp_stream_if.sink   in_ch,
    hyp_stream_if.source out_ch
);
    localparam int DW = DATA_WIDTH;
    localparam int RW = hyp_pkg::RATIO_W;
    localparam int PW = hyp_pkg::POLY_W;
    localparam int FW = hyp_pkg::FRAC_W;
    localparam int QN = 62;       // quotient bits produced by each divider
    localparam int SW = DW + 32;  // side data: m and u

    logic en;
    assign en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    // stage A: absolute values, ordering
    logic          a_v;
    logic [DW-1:0] a_m, a_n;
    logic [DW-1:0] x_s, y_s, ax, ay;
    always_comb
    begin
        x_s = in_ch.data[DW-1:0];
        y_s = in_ch.data[2*DW-1:DW];
        ax = x_s[DW-1] ? DW'(~x_s + 1'b1) : x_s;
        ay = y_s[DW-1] ? DW'(~y_s + 1'b1) : y_s;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v <= 1'b0;
        else if (en)
            a_v <= in_ch.valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_m <= (ax > ay) ? ax : ay;
            a_n <= (ax > ay) ? ay : ax;
        end
    end

    // stage B: narrow m and n to 32 bits with a shared right shift
    logic          b_v;
    logic [DW-1:0] b_m;
    logic [RW-1:0] b_mr, b_nr;
    logic [RW-1:0] mr_c, nr_c;
    always_comb
    begin
        mr_c = RW'(a_m);
        nr_c = RW'(a_n);
        for (int k = DW - RW; k >= 1; k--)
        begin
            if ((a_m >> (RW + k - 1)) != '0)
            begin
                mr_c = RW'(a_m >> k);
                nr_c = RW'(a_n >> k);
                break;
            end
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v <= 1'b0;
        else if (en)
            b_v <= a_v;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_m  <= a_m;
            b_mr <= (a_m == '0) ? RW'(1) : mr_c;
            b_nr <= nr_c;
        end
    end

    // divider 1: t = (n << 30) / m, 62 stages
    logic [QN:0]          d1_v;
    logic [PW:0]          d1_rem [QN+1];
    logic [QN-1:0]        d1_num [QN+1];
    logic [PW-1:0]        d1_den [QN+1];
    logic [SW-1:0]        d1_side [QN+1];
    assign d1_v[0]    = b_v;
    assign d1_rem[0]  = '0;
    assign d1_num[0]  = {b_nr, FW'(0)};
    assign d1_den[0]  = PW'(b_mr);
    assign d1_side[0] = {b_m, 32'd0};
    for (genvar i = 0; i < QN; i++)
    begin : g_div1
        hyp_div_stage #(.NUM_W(QN), .DEN_W(PW), .SIDE_W(SW)) u_st (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(d1_v[i]), .in_rem(d1_rem[i]), .in_num(d1_num[i]),
            .in_den(d1_den[i]), .in_side(d1_side[i]),
            .out_valid(d1_v[i+1]), .out_rem(d1_rem[i+1]), .out_num(d1_num[i+1]),
            .out_den(d1_den[i+1]), .out_side(d1_side[i+1]));
    end

    // stage C: t*t
    logic          c_v;
    logic [DW-1:0] c_m;
    logic [63:0]   c_tt;
    logic [RW-1:0] t_c;
    assign t_c = RW'(d1_num[QN]);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v <= 1'b0;
        else if (en)
            c_v <= d1_v[QN];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_m  <= d1_side[QN][SW-1:32];
            c_tt <= 64'(t_c) * 64'(t_c);
        end
    end

    // stage D: u
    logic          d_v;
    logic [DW-1:0] d_m;
    logic [RW-1:0] d_u;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v <= 1'b0;
        else if (en)
            d_v <= c_v;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_m <= c_m;
            d_u <= RW'((34'(1) << FW) + 34'(c_tt >> FW) >> 1);
        end
    end

    // Horner: three steps, each a multiply stage and an add stage
    logic [2:0]    h_v;
    logic [DW-1:0] h_m [3];
    logic [RW-1:0] h_u [3];
    logic [PW-1:0] h_p [3], h_q [3];
    logic [2:0]    hm_v;
    logic [DW-1:0] hm_m [3];
    logic [RW-1:0] hm_u [3];
    logic [65:0]   hm_p [3], hm_q [3];
    logic [PW-1:0] cp [3], cq [3];
    assign cp[0] = hyp_pkg::CP2;
    assign cp[1] = hyp_pkg::CP1;
    assign cp[2] = hyp_pkg::CP0;
    assign cq[0] = hyp_pkg::CQ2;
    assign cq[1] = hyp_pkg::CQ1;
    assign cq[2] = hyp_pkg::CQ0;
    for (genvar j = 0; j < 3; j++)
    begin : g_horner
        logic          iv;
        logic [DW-1:0] im;
        logic [RW-1:0] iu;
        logic [PW-1:0] ip, iq;
        if (j == 0)
        begin : g_first
            assign iv = d_v;
            assign im = d_m;
            assign iu = d_u;
            assign ip = hyp_pkg::CP3;
            assign iq = hyp_pkg::CQ3;
        end
        else
        begin : g_next
            assign iv = h_v[j-1];
            assign im = h_m[j-1];
            assign iu = h_u[j-1];
            assign ip = h_p[j-1];
            assign iq = h_q[j-1];
        end
        // multiply accumulators by u
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                hm_v[j] <= 1'b0;
                h_v[j]  <= 1'b0;
            end
            else if (en)
            begin
                hm_v[j] <= iv;
                h_v[j]  <= hm_v[j];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hm_m[j] <= im;
                hm_u[j] <= iu;
                hm_p[j] <= 66'(ip) * 66'(iu);
                hm_q[j] <= 66'(iq) * 66'(iu);
                h_m[j]  <= hm_m[j];
                h_u[j]  <= hm_u[j];
                h_p[j]  <= cp[j] + PW'(hm_p[j] >> FW);
                h_q[j]  <= cq[j] + PW'(hm_q[j] >> FW);
            end
        end
    end

    // divider 2: s = (num << 30) / den
    logic [QN:0]   d2_v;
    logic [PW:0]   d2_rem [QN+1];
    logic [QN+3:0] d2_num [QN+1];
    logic [PW-1:0] d2_den [QN+1];
    logic [SW-1:0] d2_side [QN+1];
    // the top two dividend bits start as the remainder (always below den);
    // the low 62 bits go through the stages, MSB first
    assign d2_v[0]    = h_v[2];
    assign d2_rem[0]  = (PW+1)'(h_p[2][PW-1:QN-FW]);
    assign d2_num[0]  = {h_p[2][QN-FW-1:0], FW'(0), 4'b0};
    assign d2_den[0]  = h_q[2];
    assign d2_side[0] = {h_m[2], h_u[2]};
    for (genvar i = 0; i < QN; i++)
    begin : g_div2
        hyp_div_stage #(.NUM_W(QN+4), .DEN_W(PW), .SIDE_W(SW)) u_st (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(d2_v[i]), .in_rem(d2_rem[i]),
            .in_num(d2_num[i]),
            .in_den(d2_den[i]), .in_side(d2_side[i]),
            .out_valid(d2_v[i+1]), .out_rem(d2_rem[i+1]), .out_num(d2_num[i+1]),
            .out_den(d2_den[i+1]), .out_side(d2_side[i+1]));
    end

    // guard s against zero
    logic [PW-1:0] s_c;
    always_comb
    begin
        s_c = PW'(d2_num[QN]);
        if (s_c == '0)
            s_c = PW'(1);
    end

    // divider 3: u << 30 / s; s carried in the side word for the Newton sum
    localparam int SW3 = DW + PW;
    logic [QN:0]   d3_v;
    logic [PW:0]   d3_rem [QN+1];
    logic [QN-1:0] d3_num [QN+1];
    logic [PW-1:0] d3_den [QN+1];
    logic [SW3-1:0] d3_side [QN+1];
    assign d3_v[0]    = d2_v[QN];
    assign d3_rem[0]  = '0;
    assign d3_num[0]  = {d2_side[QN][31:0], FW'(0)};
    assign d3_den[0]  = s_c;
    assign d3_side[0] = {d2_side[QN][SW-1:32], s_c};
    for (genvar i = 0; i < QN; i++)
    begin : g_div3
        hyp_div_stage #(.NUM_W(QN), .DEN_W(PW), .SIDE_W(SW3)) u_st (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(d3_v[i]), .in_rem(d3_rem[i]), .in_num(d3_num[i]),
            .in_den(d3_den[i]), .in_side(d3_side[i]),
            .out_valid(d3_v[i+1]), .out_rem(d3_rem[i+1]), .out_num(d3_num[i+1]),
            .out_den(d3_den[i+1]), .out_side(d3_side[i+1]));
    end

    // stage E: r = s + u/s
    logic          e_v;
    logic [DW-1:0] e_m;
    logic [PW:0]   e_r;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_v <= 1'b0;
        else if (en)
            e_v <= d3_v[QN];
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_m <= d3_side[QN][SW3-1:PW];
            e_r <= (PW+1)'(d3_side[QN][PW-1:0]) + (PW+1)'(d3_num[QN]);
        end
    end

    // stage F: g = r * INV_SQRT2 >> 30
    logic          f_v;
    logic [DW-1:0] f_m;
    logic [66:0]   f_prod;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_v <= 1'b0;
        else if (en)
            f_v <= e_v;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_m    <= e_m;
            f_prod <= 67'(e_r) * 67'(hyp_pkg::INV_SQRT2);
        end
    end

    // stage G: split product m * g into high and low parts
    localparam int GW = 36;
    logic          g_v;
    logic [GW-1:0] g_g;
    logic [DW+GW-1:0] g_hi;
    logic [16+GW-1:0] g_lo;
    logic          g_zero;
    always_comb
        g_g = GW'(f_prod >> FW);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_v <= 1'b0;
        else if (en)
            g_v <= f_v;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_zero <= (f_m == '0);
            g_hi   <= (DW+GW)'(f_m >> 16) * (DW+GW)'(g_g);
            g_lo   <= (16+GW)'(f_m[15:0]) * (16+GW)'(g_g);
        end
    end

    // output register: combine, saturate, zero case
    logic [DW+GW-1:0] res_c;
    logic             o_v_reg;
    logic [DW-1:0]    o_d_reg;
    always_comb
        res_c = (g_hi >> 14)
              + (DW+GW)'(((64'(g_hi[13:0]) << 16) + 64'(g_lo)) >> FW);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (en)
            o_v_reg <= g_v;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (g_zero)
                o_d_reg <= '0;
            else if ((res_c >> DW) != '0)
                o_d_reg <= '1;
            else
                o_d_reg <= DW'(res_c);
        end
    end
    assign out_ch.valid = o_v_reg;
    assign out_ch.data  = o_d_reg;

    // a stalled output holds its item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("output item changed under stall");
    // a zero larger magnitude gives a zero result
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        en && g_v && g_zero |=> out_ch.data == '0)
        else $error("zero vector gave non-zero magnitude");
    // the first divider never sees a zero divisor
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        b_v |-> b_mr != '0)
        else $error("zero divisor in ratio divider");
endmodule

// ===== tb/sv/hyp_mag_scoreboard.sv =====
// Scoreboard class for the vector magnitude testbench: predicts magnitudes.
// Depends on nothing beyond plain SystemVerilog; used by tb_top.
`timescale 1ns / 1ps

class hyp_mag_scoreboard;
    localparam logic [63:0] CP0 = 64'd79806610;
    localparam logic [63:0] CP1 = 64'd2399895553;
    localparam logic [63:0] CP2 = 64'd5670759153;
    localparam logic [63:0] CP3 = 64'd1591954984;
    localparam logic [63:0] CQ0 = 64'd669336246;
    localparam logic [63:0] CQ1 = 64'd4768523365;
    localparam logic [63:0] CQ2 = 64'd4036121244;
    localparam logic [63:0] CQ3 = 64'd268435456;
    localparam logic [63:0] RSQ2 = 64'd759250125;

    logic [31:0] pending_mag[$];
    int unsigned mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Evaluate a cubic in u, Q4.30 coefficients, flooring each step
    function logic [63:0] cubic(logic [63:0] c0, logic [63:0] c1, logic [63:0] c2,
                                logic [63:0] c3, logic [63:0] u);
        logic [63:0] acc;
        acc = c3;
        acc = c2 + ((acc * u) >> 30);
        acc = c1 + ((acc * u) >> 30);
        acc = c0 + ((acc * u) >> 30);
        return acc;
    endfunction

    function logic [31:0] magnitude_of(logic [31:0] x, logic [31:0] y);
        logic [63:0] ax, ay, m, n, mr, nr, t, u, num, den, s, r, g, hi, lo, res;
        ax = x[31] ? {32'd0, -x} : {32'd0, x};
        ay = y[31] ? {32'd0, -y} : {32'd0, y};
        // equal magnitudes take the second component as the larger
        if (ax > ay)
        begin
            m = ax;
            n = ay;
        end
        else
        begin
            m = ay;
            n = ax;
        end
        if (m == 0)
            return 32'd0;
        mr = m;
        nr = n;
        while ((mr >> 32) != 0)
        begin
            mr = mr >> 1;
            nr = nr >> 1;
        end
        t = (nr << 30) / mr;
        u = ((64'd1 << 30) + ((t * t) >> 30)) >> 1;
        num = cubic(CP0, CP1, CP2, CP3, u);
        den = cubic(CQ0, CQ1, CQ2, CQ3, u);
        s = (num << 30) / den;
        if (s == 0)
            s = 1;
        r = s + ((u << 30) / s);
        g = (r * RSQ2) >> 30;
        hi = (m >> 16) * g;
        lo = (m & 64'hFFFF) * g;
        res = (hi >> 14) + ((((hi & 64'h3FFF) << 16) + lo) >> 30);
        if (res > 64'hFFFF_FFFF)
            res = 64'hFFFF_FFFF;
        return res[31:0];
    endfunction

    function void note_input(logic [31:0] x, logic [31:0] y);
        pending_mag.push_back(magnitude_of(x, y));
    endfunction

    function void check_result(logic [31:0] got);
        logic [31:0] want;
        if (pending_mag.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected magnitude %h with nothing pending", got);
            return;
        end
        want = pending_mag.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("magnitude mismatch: expected %h got %h", want, got);
        end
    endfunction
endclass

// ===== tb/sv/tb_top.sv =====
// Top testbench for the vector magnitude pipeline: random and directed items.
// Depends on hyp_pkg, hyp_stream_if, the top level and hyp_mag_scoreboard.
`timescale 1ns / 1ps

module tb_top;
    localparam int N_RANDOM = 1300;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic hold_sink;
    logic no_idle;
    int unsigned cycles;

    hyp_stream_if #(.WIDTH(64)) in_ch ();
    hyp_stream_if #(.WIDTH(32)) out_ch ();

    hyp_mag_scoreboard mag_sb;

    hypotenuse_rational_newton_top #(.DATA_WIDTH(32)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        hold_sink = 1'b0;
        no_idle = 1'b0;
        mag_sb = new();
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Check results and randomise ready; a long hold-off is forced by hold_sink
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                mag_sb.check_result(out_ch.data);
            out_ch.ready <= !hold_sink && (no_idle || $urandom_range(99) >= 21);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one item and hold it until accepted
    task automatic send_item(logic [31:0] x, logic [31:0] y);
        while (!no_idle && $urandom_range(99) < 21)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {y, x};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        mag_sb.note_input(x, y);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (mag_sb.pending_mag.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return $urandom_range(8) - 4;
            3: return {{16{1'b0}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Long receiver hold-off counted in its own process
    initial
    begin
        @(posedge rst_n);
        repeat (400) @(posedge clk);
        hold_sink <= 1'b1;
        repeat (300) @(posedge clk);
        hold_sink <= 1'b0;
    end

    initial
    begin
        logic [31:0] cx, cy;
        @(posedge rst_n);
        @(posedge clk);
        // directed: zeros, extremes, most negative, equal magnitudes
        send_item(32'd0, 32'd0);
        send_item(32'd0, 32'h0001_0000);
        send_item(32'h0001_0000, 32'd0);
        send_item(32'h8000_0000, 32'h8000_0000);
        send_item(32'h8000_0000, 32'd0);
        send_item(32'd0, 32'h8000_0000);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h8000_0000);
        send_item(32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'd1, 32'd1);
        send_item(32'h0003_0000, 32'h0004_0000);
        send_item(32'hFFFD_0000, 32'h0004_0000);
        send_item(32'h0004_0000, 32'hFFFD_0000);
        send_item(32'h0005_0000, 32'hFFFB_0000);
        send_item(32'd1, 32'h7FFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'd0);
        send_item(32'hAAAA_AAAA, 32'h5555_5555);
        send_item(32'h5555_5555, 32'hAAAA_AAAA);
        // sender pauses until every result is in
        drain_results();
        for (int i = 0; i < N_RANDOM; i++)
        begin
            // stretch with no idling on either side
            if (i == 700)
                no_idle = 1'b1;
            if (i == 900)
                no_idle = 1'b0;
            cx = pick_coord();
            cy = ($urandom_range(9) == 0) ? cx : pick_coord();
            if ($urandom_range(9) == 0)
                cy = -cx;
            send_item(cx, cy);
        end
        drain_results();
        repeat (150) @(posedge clk);
        if (mag_sb.mismatches == 0 && mag_sb.pending_mag.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
